// ----- hdl/jkaos_pkg.sv -----
// ----------------------------------------------------------------------------
// jkaos_pkg
// shared types, character codes and register indexes of the keyed json array
// object splitter
// ----------------------------------------------------------------------------
`default_nettype none

package jkaos_pkg;

	localparam int unsigned MAX_KEY_LEN_DEF = 16;
	localparam int unsigned MAX_DEPTH_DEF   = 255;

	localparam int unsigned KEY_CHARS = 16;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_CHARS_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_CHARS_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH     = 2'd2;

	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;
	localparam logic [7:0] CH_LBRACE   = 8'h7B;
	localparam logic [7:0] CH_RBRACE   = 8'h7D;
	localparam logic [7:0] CH_QUOTE    = 8'h22;
	localparam logic [7:0] CH_BSLASH   = 8'h5C;

	localparam logic [1:0] ST_KEY_NOT_FOUND = 2'd0;
	localparam logic [1:0] ST_NO_ARRAY      = 2'd1;
	localparam logic [1:0] ST_ARRAY_CLOSED  = 2'd2;
	localparam logic [1:0] ST_ENDED_IN_ARR  = 2'd3;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_input;
	} item_t;

	typedef struct packed {
		logic [KEY_CHARS-1:0][7:0] chars;
		logic [4:0]                length;
	} key_cfg_t;

	typedef struct packed {
		logic [7:0]  byte_out;
		logic        is_object_byte;
		logic        object_last;
		logic        is_status;
		logic [1:0]  status;
		logic [15:0] object_count;
		logic        partial_dropped;
	} result_t;

endpackage

`default_nettype wire

// ----- hdl/jkaos_if.sv -----
// ----------------------------------------------------------------------------
// jkaos_if
// valid/ready channels of the splitter: text bytes, results and register writes
// ----------------------------------------------------------------------------
`default_nettype none

interface jkaos_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_input;

	modport source (output valid, output data_byte, output end_of_input, input ready);
	modport sink (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface jkaos_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  byte_out;
	logic        is_object_byte;
	logic        object_last;
	logic        is_status;
	logic [1:0]  status;
	logic [15:0] object_count;
	logic        partial_dropped;

	modport source (output valid, output byte_out, output is_object_byte,
		output object_last, output is_status, output status, output object_count,
		output partial_dropped, input ready);
	modport sink (input valid, input byte_out, input is_object_byte,
		input object_last, input is_status, input status, input object_count,
		input partial_dropped, output ready);
endinterface

interface jkaos_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [jkaos_pkg::CFG_IDX_W-1:0] index;
	logic [63:0]                    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/jkaos_scan_core.sv -----
// ----------------------------------------------------------------------------
// jkaos_scan_core
// scan state and its next-state logic; yields at most one result per item
// ----------------------------------------------------------------------------
`default_nettype none

module jkaos_scan_core #(
	parameter int unsigned MAX_KEY_LEN = jkaos_pkg::MAX_KEY_LEN_DEF,
	parameter int unsigned MAX_DEPTH   = jkaos_pkg::MAX_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire jkaos_pkg::key_cfg_t key_cfg,
	input  wire jkaos_pkg::item_t    item,
	input  wire logic               step,
	output logic                    res_valid,
	output jkaos_pkg::result_t      res
);

	localparam int unsigned KPW = $clog2(MAX_KEY_LEN + 1);
	localparam int unsigned DW  = $clog2(MAX_DEPTH + 1);
	localparam logic [KPW-1:0] KEY_MAX = KPW'(MAX_KEY_LEN);
	localparam logic [DW-1:0]  DEPTH_MAX = DW'(MAX_DEPTH);

	typedef enum logic [2:0] {
		PH_KEY,
		PH_BRACKET,
		PH_ARRAY,
		PH_OBJECT,
		PH_DONE
	} phase_t;

	phase_t          phase_q, phase_n;
	logic            in_quotes_q, in_quotes_n;
	logic            escape_q, escape_n;
	logic [KPW-1:0]  key_pos_q, key_pos_n;
	logic            mismatch_q, mismatch_n;
	logic [DW-1:0]   depth_q, depth_n;
	logic [15:0]     done_q, done_n;

	logic [KPW-1:0]  eff_len;
	logic [7:0]      key_ch;
	logic [7:0]      c;
	logic [DW-1:0]   depth_dec;

	assign c = item.data_byte;
	assign eff_len = (key_cfg.length > 5'(MAX_KEY_LEN)) ? KEY_MAX : KPW'(key_cfg.length);
	assign key_ch = key_cfg.chars[4'(key_pos_q)];
	assign depth_dec = (depth_q != '0) ? depth_q - DW'(1) : depth_q;

	always_comb begin
		phase_n     = phase_q;
		in_quotes_n = in_quotes_q;
		escape_n    = escape_q;
		key_pos_n   = key_pos_q;
		mismatch_n  = mismatch_q;
		depth_n     = depth_q;
		done_n      = done_q;
		res_valid   = 1'b0;
		res         = '0;

		if (item.end_of_input) begin
			res.is_status    = 1'b1;
			res.object_count = done_q;
			case (phase_q)
				PH_KEY: begin
					res_valid  = 1'b1;
					res.status = jkaos_pkg::ST_KEY_NOT_FOUND;
				end
				PH_BRACKET: begin
					res_valid  = 1'b1;
					res.status = jkaos_pkg::ST_NO_ARRAY;
				end
				PH_ARRAY: begin
					res_valid  = 1'b1;
					res.status = jkaos_pkg::ST_ENDED_IN_ARR;
				end
				PH_OBJECT: begin
					res_valid           = 1'b1;
					res.status          = jkaos_pkg::ST_ENDED_IN_ARR;
					res.partial_dropped = 1'b1;
				end
				default: begin
					res_valid = 1'b0;
				end
			endcase
			phase_n     = PH_KEY;
			in_quotes_n = 1'b0;
			escape_n    = 1'b0;
			key_pos_n   = '0;
			mismatch_n  = 1'b0;
			depth_n     = '0;
			done_n      = '0;
		end else begin
			case (phase_q)
				PH_KEY: begin
					if (escape_q) begin
						escape_n = 1'b0;
					end else if (c == jkaos_pkg::CH_BSLASH && in_quotes_q) begin
						escape_n = 1'b1;
					end else if (c == jkaos_pkg::CH_QUOTE) begin
						if (!in_quotes_q) begin
							in_quotes_n = 1'b1;
							key_pos_n   = '0;
							mismatch_n  = 1'b0;
						end else begin
							in_quotes_n = 1'b0;
							if (!mismatch_q && key_pos_q == eff_len) begin
								phase_n = PH_BRACKET;
							end
						end
					end else if (in_quotes_q && !mismatch_q) begin
						if (key_pos_q < eff_len && c == key_ch) begin
							key_pos_n = key_pos_q + KPW'(1);
						end else begin
							mismatch_n = 1'b1;
						end
					end
				end
				PH_BRACKET: begin
					if (c == jkaos_pkg::CH_LBRACKET) begin
						phase_n = PH_ARRAY;
					end else if (c == jkaos_pkg::CH_RBRACKET || c == jkaos_pkg::CH_RBRACE) begin
						res_valid        = 1'b1;
						res.is_status    = 1'b1;
						res.status       = jkaos_pkg::ST_NO_ARRAY;
						res.object_count = done_q;
						phase_n          = PH_DONE;
					end
				end
				PH_ARRAY: begin
					if (c == jkaos_pkg::CH_LBRACE) begin
						in_quotes_n        = 1'b0;
						escape_n           = 1'b0;
						depth_n            = DW'(1);
						phase_n            = PH_OBJECT;
						res_valid          = 1'b1;
						res.byte_out       = c;
						res.is_object_byte = 1'b1;
					end else if (c == jkaos_pkg::CH_RBRACKET) begin
						res_valid        = 1'b1;
						res.is_status    = 1'b1;
						res.status       = jkaos_pkg::ST_ARRAY_CLOSED;
						res.object_count = done_q;
						phase_n          = PH_DONE;
					end
				end
				PH_OBJECT: begin
					res_valid          = 1'b1;
					res.byte_out       = c;
					res.is_object_byte = 1'b1;
					if (escape_q) begin
						escape_n = 1'b0;
					end else if (c == jkaos_pkg::CH_BSLASH && in_quotes_q) begin
						escape_n = 1'b1;
					end else if (c == jkaos_pkg::CH_QUOTE) begin
						in_quotes_n = !in_quotes_q;
					end else if (!in_quotes_q) begin
						if (c == jkaos_pkg::CH_LBRACE) begin
							if (depth_q < DEPTH_MAX) begin
								depth_n = depth_q + DW'(1);
							end
						end else if (c == jkaos_pkg::CH_RBRACE) begin
							depth_n = depth_dec;
							if (depth_dec == '0) begin
								res.object_last = 1'b1;
								phase_n         = PH_ARRAY;
								if (done_q != jkaos_pkg::COUNT_MAX) begin
									done_n = done_q + 16'd1;
								end
							end
						end
					end
				end
				default: begin
					phase_n = phase_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_KEY;
			in_quotes_q <= 1'b0;
			escape_q    <= 1'b0;
			key_pos_q   <= '0;
			mismatch_q  <= 1'b0;
			depth_q     <= '0;
			done_q      <= '0;
		end else if (step) begin
			phase_q     <= phase_n;
			in_quotes_q <= in_quotes_n;
			escape_q    <= escape_n;
			key_pos_q   <= key_pos_n;
			mismatch_q  <= mismatch_n;
			depth_q     <= depth_n;
			done_q      <= done_n;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/jkaos_out_stage.sv -----
// ----------------------------------------------------------------------------
// jkaos_out_stage
// result register in front of the output channel
// ----------------------------------------------------------------------------
`default_nettype none

module jkaos_out_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire jkaos_pkg::result_t res,
	output logic                   busy,
	jkaos_out_if.source            result
);

	logic               valid_q;
	jkaos_pkg::result_t res_q;

	assign busy = valid_q && !result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!busy) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (!busy && load) begin
			res_q <= res;
		end
	end

	assign result.valid           = valid_q;
	assign result.byte_out        = res_q.byte_out;
	assign result.is_object_byte  = res_q.is_object_byte;
	assign result.object_last     = res_q.object_last;
	assign result.is_status       = res_q.is_status;
	assign result.status          = res_q.status;
	assign result.object_count    = res_q.object_count;
	assign result.partial_dropped = res_q.partial_dropped;

endmodule

`default_nettype wire

// ----- hdl/json_keyed_array_object_splitter_top.sv -----
// ----------------------------------------------------------------------------
// json_keyed_array_object_splitter_top
// finds a keyed json array in a byte stream and passes out its objects
// ----------------------------------------------------------------------------
// Takes one text byte per cycle unless the output stalls: a byte goes
// into the input register, the scan logic updates its state and forms the
// result in the same cycle, and the result register holds it for the output
// channel, so a byte's result is offered on the output channel once it has
// passed the input register and then the result register. A new byte is taken
// every cycle unless the input register holds a byte while a result waits in
// the output register and the sink is not ready. Register writes must come
// only while the block is idle; the key is compared from the 16 stored
// characters up to key_length, clamped to MAX_KEY_LEN.
`default_nettype none

module json_keyed_array_object_splitter_top #(
	parameter int unsigned MAX_KEY_LEN = jkaos_pkg::MAX_KEY_LEN_DEF,
	parameter int unsigned MAX_DEPTH   = jkaos_pkg::MAX_DEPTH_DEF
) (
	input wire logic    clk,
	input wire logic    arst_n,
	jkaos_in_if.sink    text,
	jkaos_out_if.source result,
	jkaos_cfg_if.sink   cfg
);

	logic [63:0]         key_low_q;
	logic [63:0]         key_high_q;
	logic [4:0]          key_len_q;
	jkaos_pkg::key_cfg_t key_cfg;

	logic                valid_s1;
	jkaos_pkg::item_t    item_s1;
	logic                step;
	logic                busy;
	logic                res_valid;
	jkaos_pkg::result_t  res;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
			key_len_q  <= 5'd1;
		end else if (cfg.valid) begin
			case (cfg.index)
				jkaos_pkg::REG_KEY_CHARS_LOW: begin
					key_low_q <= cfg.data;
				end
				jkaos_pkg::REG_KEY_CHARS_HIGH: begin
					key_high_q <= cfg.data;
				end
				jkaos_pkg::REG_KEY_LENGTH: begin
					key_len_q <= cfg.data[4:0];
				end
				default: begin
					key_len_q <= key_len_q;
				end
			endcase
		end
	end

	assign key_cfg.chars  = {key_high_q, key_low_q};
	assign key_cfg.length = key_len_q;

	assign step       = valid_s1 && !busy;
	assign text.ready = !valid_s1 || !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			item_s1.data_byte    <= text.data_byte;
			item_s1.end_of_input <= text.end_of_input;
		end
	end

	jkaos_scan_core #(
		.MAX_KEY_LEN (MAX_KEY_LEN),
		.MAX_DEPTH   (MAX_DEPTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_cfg   (key_cfg),
		.item      (item_s1),
		.step      (step),
		.res_valid (res_valid),
		.res       (res)
	);

	jkaos_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (step && res_valid),
		.res    (res),
		.busy   (busy),
		.result (result)
	);

endmodule

`default_nettype wire

// ----- sim/tb_json_keyed_array_object_splitter_top.sv -----
// ----------------------------------------------------------------------------
// tb_json_keyed_array_object_splitter_top
// self-checking bench for the keyed json array object splitter: a short table
// of hand-made text, then generated json documents under several keys, each
// item predicted in the bench and checked field by field against the output
// ----------------------------------------------------------------------------

module tb_json_keyed_array_object_splitter_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT   = 1_000_000;
	localparam int unsigned DRAIN_CYCLES  = 8;
	localparam int unsigned HOLD_CYCLES   = 200;
	localparam int unsigned PHASE_ITEMS   = 40;
	localparam int unsigned DEPTH_OPENS   = jkaos_pkg::MAX_DEPTH_DEF + 2;
	localparam int unsigned DEPTH_CLOSES  = 4;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [2:0] {
		SCAN_KEY,
		SCAN_BRACKET,
		SCAN_ARRAY,
		SCAN_OBJECT,
		SCAN_DONE
	} scan_phase_t;

	typedef struct packed {
		logic [7:0]  data;
		logic        eoi;
		logic        typed;
		logic [1:0]  st;
		logic [15:0] count;
		logic        partial;
	} directed_row_t;

	// reset key is one nul character
	localparam directed_row_t DIRECTED_ROWS [27] = '{
		'{8'h00,                  1'b1, 1'b1, jkaos_pkg::ST_KEY_NOT_FOUND, 16'd0, 1'b0},
		'{jkaos_pkg::CH_QUOTE,    1'b0, 1'b0, jkaos_pkg::ST_KEY_NOT_FOUND, 16'd0, 1'b0},
		'{8'h00,                  1'b0, 1'b0, jkaos_pkg::ST_KEY_NOT_FOUND, 16'd0, 1'b0},
		'{jkaos_pkg::CH_QUOTE,    1'b0, 1'b0, jkaos_pkg::ST_KEY_NOT_FOUND, 16'd0, 1'b0},
		'{jkaos_pkg::CH_RBRACE,   1'b0, 1'b1, jkaos_pkg::ST_NO_ARRAY,      16'd0, 1'b0},
		'{8'hFF,                  1'b0, 1'b0, jkaos_pkg::ST_KEY_NOT_FOUND, 16'd0, 1'b0},
		'{8'hAA,                  1'b1, 1'b0, jkaos_pkg::ST_KEY_NOT_FOUND, 16'd0, 1'b0},
		'{jkaos_pkg::CH_QUOTE,    1'b0, 1'b0, jkaos_pkg::ST_KEY_NOT_FOUND, 16'd0, 1'b0},
		'{jkaos_pkg::CH_BSLASH,   1'b0, 1'b0, jkaos_pkg::ST_KEY_NOT_FOUND, 16'd0, 1'b0},
		'{jkaos_pkg::CH_QUOTE,    1'b0, 1'b0, jkaos_pkg::ST_KEY_NOT_FOUND, 16'd0, 1'b0},
		'{8'h00,                  1'b0, 1'b0, jkaos_pkg::ST_KEY_NOT_FOUND, 16'd0, 1'b0},
		'{jkaos_pkg::CH_QUOTE,    1'b0, 1'b0, jkaos_pkg::ST_KEY_NOT_FOUND, 16'd0, 1'b0},
		'{jkaos_pkg::CH_LBRACKET, 1'b0, 1'b0, jkaos_pkg::ST_KEY_NOT_FOUND, 16'd0, 1'b0},
		'{jkaos_pkg::CH_LBRACE,   1'b0, 1'b0, jkaos_pkg::ST_KEY_NOT_FOUND, 16'd0, 1'b0},
		'{jkaos_pkg::CH_QUOTE,    1'b0, 1'b0, jkaos_pkg::ST_KEY_NOT_FOUND, 16'd0, 1'b0},
		'{jkaos_pkg::CH_RBRACE,   1'b0, 1'b0, jkaos_pkg::ST_KEY_NOT_FOUND, 16'd0, 1'b0},
		'{jkaos_pkg::CH_BSLASH,   1'b0, 1'b0, jkaos_pkg::ST_KEY_NOT_FOUND, 16'd0, 1'b0},
		'{jkaos_pkg::CH_QUOTE,    1'b0, 1'b0, jkaos_pkg::ST_KEY_NOT_FOUND, 16'd0, 1'b0},
		'{jkaos_pkg::CH_QUOTE,    1'b0, 1'b0, jkaos_pkg::ST_KEY_NOT_FOUND, 16'd0, 1'b0},
		'{jkaos_pkg::CH_RBRACE,   1'b0, 1'b0, jkaos_pkg::ST_KEY_NOT_FOUND, 16'd0, 1'b0},
		'{jkaos_pkg::CH_LBRACE,   1'b0, 1'b0, jkaos_pkg::ST_KEY_NOT_FOUND, 16'd0, 1'b0},
		'{8'h55,                  1'b1, 1'b1, jkaos_pkg::ST_ENDED_IN_ARR,  16'd1, 1'b1},
		'{jkaos_pkg::CH_QUOTE,    1'b0, 1'b0, jkaos_pkg::ST_KEY_NOT_FOUND, 16'd0, 1'b0},
		'{8'h00,                  1'b0, 1'b0, jkaos_pkg::ST_KEY_NOT_FOUND, 16'd0, 1'b0},
		'{8'h01,                  1'b0, 1'b0, jkaos_pkg::ST_KEY_NOT_FOUND, 16'd0, 1'b0},
		'{jkaos_pkg::CH_QUOTE,    1'b0, 1'b0, jkaos_pkg::ST_KEY_NOT_FOUND, 16'd0, 1'b0},
		'{8'h00,                  1'b1, 1'b1, jkaos_pkg::ST_KEY_NOT_FOUND, 16'd0, 1'b0}
	};

	logic clk;
	logic arst_n;

	jkaos_in_if  text();
	jkaos_out_if result();
	jkaos_cfg_if cfg();

	json_keyed_array_object_splitter_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text.sink),
		.result (result.source),
		.cfg    (cfg.sink)
	);

	logic [jkaos_pkg::KEY_CHARS-1:0][7:0] key_chars;
	logic [4:0]                           key_len;

	scan_phase_t scan_phase;
	logic        in_string;
	logic        escape_next;
	logic [4:0]  key_pos;
	logic        key_failed;
	logic [7:0]  brace_level;
	logic [15:0] objects_seen;

	jkaos_pkg::result_t expected_results [$];
	jkaos_pkg::item_t   doc_q [$];
	int unsigned        mismatches;
	bit                 hold_req;
	bit                 idling_on;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void expect_result(jkaos_pkg::result_t r);
		expected_results.insert(expected_results.size(), r);
	endfunction

	function automatic void queue_item(jkaos_pkg::item_t it);
		doc_q.insert(doc_q.size(), it);
	endfunction

	function automatic int unsigned key_span();
		return (key_len > jkaos_pkg::MAX_KEY_LEN_DEF) ? jkaos_pkg::MAX_KEY_LEN_DEF : key_len;
	endfunction

	function automatic void restart_scan();
		scan_phase   = SCAN_KEY;
		in_string    = 1'b0;
		escape_next  = 1'b0;
		key_pos      = '0;
		key_failed   = 1'b0;
		brace_level  = '0;
		objects_seen = '0;
	endfunction

	function automatic jkaos_pkg::result_t mk_status(logic [1:0] st, logic [15:0] count,
		logic partial);
		jkaos_pkg::result_t r;
		r = '0;
		r.is_status       = 1'b1;
		r.status          = st;
		r.object_count    = count;
		r.partial_dropped = partial;
		return r;
	endfunction

	function automatic jkaos_pkg::result_t byte_result(logic [7:0] b, logic last);
		jkaos_pkg::result_t r;
		r = '0;
		r.byte_out       = b;
		r.is_object_byte = 1'b1;
		r.object_last    = last;
		return r;
	endfunction

	function automatic bit predict_item(input jkaos_pkg::item_t it,
		output jkaos_pkg::result_t res);
		logic [7:0] c;
		logic       last;
		bit         has;
		c    = it.data_byte;
		last = 1'b0;
		has  = 1'b0;
		res  = '0;
		if (it.end_of_input) begin
			has = (scan_phase != SCAN_DONE);
			case (scan_phase)
				SCAN_KEY:     res = mk_status(jkaos_pkg::ST_KEY_NOT_FOUND, objects_seen, 1'b0);
				SCAN_BRACKET: res = mk_status(jkaos_pkg::ST_NO_ARRAY, objects_seen, 1'b0);
				SCAN_ARRAY:   res = mk_status(jkaos_pkg::ST_ENDED_IN_ARR, objects_seen, 1'b0);
				SCAN_OBJECT:  res = mk_status(jkaos_pkg::ST_ENDED_IN_ARR, objects_seen, 1'b1);
				default:      res = '0;
			endcase
			restart_scan();
			return has;
		end
		case (scan_phase)
			SCAN_KEY: begin
				if (escape_next) begin
					escape_next = 1'b0;
				end else if (c == jkaos_pkg::CH_BSLASH && in_string) begin
					escape_next = 1'b1;
				end else if (c == jkaos_pkg::CH_QUOTE) begin
					if (!in_string) begin
						in_string  = 1'b1;
						key_pos    = '0;
						key_failed = 1'b0;
					end else begin
						in_string = 1'b0;
						if (!key_failed && key_pos == key_span())
							scan_phase = SCAN_BRACKET;
					end
				end else if (in_string && !key_failed) begin
					if (key_pos < key_span() && c == key_chars[key_pos[3:0]])
						key_pos++;
					else
						key_failed = 1'b1;
				end
			end
			SCAN_BRACKET: begin
				if (c == jkaos_pkg::CH_LBRACKET) begin
					scan_phase = SCAN_ARRAY;
				end else if (c == jkaos_pkg::CH_RBRACKET || c == jkaos_pkg::CH_RBRACE) begin
					res        = mk_status(jkaos_pkg::ST_NO_ARRAY, objects_seen, 1'b0);
					has        = 1'b1;
					scan_phase = SCAN_DONE;
				end
			end
			SCAN_ARRAY: begin
				if (c == jkaos_pkg::CH_LBRACE) begin
					in_string   = 1'b0;
					escape_next = 1'b0;
					brace_level = 8'd1;
					scan_phase  = SCAN_OBJECT;
					res         = byte_result(c, 1'b0);
					has         = 1'b1;
				end else if (c == jkaos_pkg::CH_RBRACKET) begin
					res        = mk_status(jkaos_pkg::ST_ARRAY_CLOSED, objects_seen, 1'b0);
					has        = 1'b1;
					scan_phase = SCAN_DONE;
				end
			end
			SCAN_OBJECT: begin
				if (escape_next) begin
					escape_next = 1'b0;
				end else if (c == jkaos_pkg::CH_BSLASH && in_string) begin
					escape_next = 1'b1;
				end else if (c == jkaos_pkg::CH_QUOTE) begin
					in_string = !in_string;
				end else if (!in_string) begin
					if (c == jkaos_pkg::CH_LBRACE) begin
						if (brace_level < jkaos_pkg::MAX_DEPTH_DEF)
							brace_level++;
					end else if (c == jkaos_pkg::CH_RBRACE) begin
						if (brace_level > 0)
							brace_level--;
						if (brace_level == 0) begin
							last = 1'b1;
							if (objects_seen != jkaos_pkg::COUNT_MAX)
								objects_seen++;
							scan_phase = SCAN_ARRAY;
						end
					end
				end
				res = byte_result(c, last);
				has = 1'b1;
			end
			default: has = 1'b0;
		endcase
		return has;
	endfunction

	function automatic bit is_structural(logic [7:0] b);
		return b == jkaos_pkg::CH_LBRACE || b == jkaos_pkg::CH_RBRACE ||
			b == jkaos_pkg::CH_QUOTE || b == jkaos_pkg::CH_BSLASH ||
			b == jkaos_pkg::CH_LBRACKET || b == jkaos_pkg::CH_RBRACKET;
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (is_structural(b));
		return b;
	endfunction

	function automatic logic [7:0] string_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255));
		while (b == jkaos_pkg::CH_QUOTE || b == jkaos_pkg::CH_BSLASH);
		return b;
	endfunction

	function automatic logic [63:0] key_word();
		logic [63:0] w;
		for (int i = 0; i < 8; i++)
			w[8*i +: 8] = string_byte();
		return w;
	endfunction

	function automatic void add_byte(logic [7:0] b);
		queue_item(jkaos_pkg::item_t'{b, 1'b0});
	endfunction

	function automatic void add_end();
		queue_item(jkaos_pkg::item_t'{8'($urandom_range(0, 255)), 1'b1});
	endfunction

	function automatic void add_plain(int unsigned n);
		repeat (n) add_byte(plain_byte());
	endfunction

	function automatic void add_noise(int unsigned n);
		repeat (n) begin
			if ($urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 5))
					0: add_byte(jkaos_pkg::CH_LBRACE);
					1: add_byte(jkaos_pkg::CH_RBRACE);
					2: add_byte(jkaos_pkg::CH_QUOTE);
					3: add_byte(jkaos_pkg::CH_BSLASH);
					4: add_byte(jkaos_pkg::CH_LBRACKET);
					default: add_byte(jkaos_pkg::CH_RBRACKET);
				endcase
			end else begin
				add_byte(8'($urandom_range(0, 255)));
			end
		end
	endfunction

	function automatic void add_string(int unsigned n);
		add_byte(jkaos_pkg::CH_QUOTE);
		repeat (n) begin
			if ($urandom_range(0, 5) == 0) begin
				add_byte(jkaos_pkg::CH_BSLASH);
				add_byte(8'($urandom_range(0, 255)));
			end else begin
				add_byte(string_byte());
			end
		end
		add_byte(jkaos_pkg::CH_QUOTE);
	endfunction

	// a spoiled key is one character short or one too long
	function automatic void add_key_string(bit spoil);
		int unsigned span;
		int unsigned cut;
		span = key_span();
		cut  = span;
		if (spoil && span > 0 && $urandom_range(0, 1) == 0)
			cut = span - 1;
		add_byte(jkaos_pkg::CH_QUOTE);
		for (int i = 0; i < cut; i++) begin
			if ($urandom_range(0, 7) == 0) begin
				add_byte(jkaos_pkg::CH_BSLASH);
				add_byte(8'($urandom_range(0, 255)));
			end
			add_byte(key_chars[i]);
		end
		if (spoil && cut == span)
			add_byte(string_byte());
		add_byte(jkaos_pkg::CH_QUOTE);
	endfunction

	function automatic void add_object(int unsigned levels);
		add_byte(jkaos_pkg::CH_LBRACE);
		repeat ($urandom_range(0, 4)) begin
			case ($urandom_range(0, 3))
				0: add_plain($urandom_range(1, 4));
				1: add_string($urandom_range(0, 6));
				2: begin
					if (levels > 0)
						add_object(levels - 1);
					else
						add_byte(CH_COMMA);
				end
				default: begin
					add_string($urandom_range(0, 4));
					add_byte(CH_COLON);
				end
			endcase
		end
		add_byte(jkaos_pkg::CH_RBRACE);
	endfunction

	function automatic void gen_doc(bit long_object);
		int unsigned shape;
		shape = long_object ? 9 : $urandom_range(0, 9);
		if ($urandom_range(0, 1))
			add_byte(jkaos_pkg::CH_LBRACE);
		repeat ($urandom_range(0, 2)) begin
			if ($urandom_range(0, 1))
				add_key_string(1'b1);
			else
				add_string($urandom_range(0, 8));
			add_byte(CH_COLON);
			add_string($urandom_range(0, 4));
			add_byte(CH_COMMA);
		end
		if (shape == 0) begin
			add_noise($urandom_range(1, 30));
			add_end();
			return;
		end
		add_key_string(1'b0);
		add_byte(CH_COLON);
		if (shape == 1) begin
			add_plain($urandom_range(0, 3));
			add_byte($urandom_range(0, 1) ? jkaos_pkg::CH_RBRACKET : jkaos_pkg::CH_RBRACE);
			add_noise($urandom_range(0, 6));
			add_end();
			return;
		end
		if (shape == 2) begin
			add_plain($urandom_range(0, 3));
			add_end();
			return;
		end
		add_plain($urandom_range(0, 2));
		add_byte(jkaos_pkg::CH_LBRACKET);
		if (long_object) begin
			add_byte(jkaos_pkg::CH_LBRACE);
			add_plain(60);
			add_byte(jkaos_pkg::CH_RBRACE);
		end
		repeat ($urandom_range(0, 4)) begin
			add_object(3);
			add_byte(CH_COMMA);
			if ($urandom_range(0, 2) == 0)
				add_plain($urandom_range(1, 3));
		end
		case ($urandom_range(0, 9))
			0, 1: add_end();
			2: begin
				add_byte(jkaos_pkg::CH_LBRACE);
				add_plain($urandom_range(0, 5));
				if ($urandom_range(0, 1))
					add_byte(jkaos_pkg::CH_QUOTE);
				add_end();
			end
			default: begin
				add_byte(jkaos_pkg::CH_RBRACKET);
				add_noise($urandom_range(0, 4));
				add_end();
			end
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [15:0] got_v, logic [15:0] want_v);
		$display("tb: mismatch on %s: got %0h, expected %0h at %0t ns", what, got_v, want_v,
			$time);
		mismatches++;
	endtask

	task automatic check_result(jkaos_pkg::result_t got, jkaos_pkg::result_t want);
		if (got.byte_out !== want.byte_out)
			report_mismatch("byte_out", 16'(got.byte_out), 16'(want.byte_out));
		if (got.is_object_byte !== want.is_object_byte)
			report_mismatch("is_object_byte", 16'(got.is_object_byte),
				16'(want.is_object_byte));
		if (got.object_last !== want.object_last)
			report_mismatch("object_last", 16'(got.object_last), 16'(want.object_last));
		if (got.is_status !== want.is_status)
			report_mismatch("is_status", 16'(got.is_status), 16'(want.is_status));
		if (got.status !== want.status)
			report_mismatch("status", 16'(got.status), 16'(want.status));
		if (got.object_count !== want.object_count)
			report_mismatch("object_count", got.object_count, want.object_count);
		if (got.partial_dropped !== want.partial_dropped)
			report_mismatch("partial_dropped", 16'(got.partial_dropped),
				16'(want.partial_dropped));
	endtask

	// called just after a falling edge, returns just after a falling edge once the byte has been taken
	task automatic send_item(jkaos_pkg::item_t it, bit typed = 1'b0,
		jkaos_pkg::result_t want = '0);
		jkaos_pkg::result_t res;
		if (idling_on && $urandom_range(0, 4) == 0) begin
			text.valid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		text.valid        = 1'b1;
		text.data_byte    = it.data_byte;
		text.end_of_input = it.end_of_input;
		do @(posedge clk); while (text.ready !== 1'b1);
		if (predict_item(it, res))
			expect_result(typed ? want : res);
		@(negedge clk);
	endtask

	task automatic send_doc();
		foreach (doc_q[i])
			send_item(doc_q[i]);
		doc_q.delete();
	endtask

	task automatic wait_drained();
		text.valid = 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic settle();
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [jkaos_pkg::CFG_IDX_W-1:0] idx, logic [63:0] value);
		cfg.valid = 1'b1;
		cfg.index = idx;
		cfg.data  = value;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		case (idx)
			jkaos_pkg::REG_KEY_CHARS_LOW:  key_chars[7:0]  = value;
			jkaos_pkg::REG_KEY_CHARS_HIGH: key_chars[15:8] = value;
			jkaos_pkg::REG_KEY_LENGTH:     key_len         = value[4:0];
			default:                       key_len         = key_len;
		endcase
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	task automatic configure(logic [63:0] low, logic [63:0] high, logic [4:0] len);
		settle();
		write_reg(jkaos_pkg::REG_KEY_CHARS_LOW, low);
		write_reg(jkaos_pkg::REG_KEY_CHARS_HIGH, high);
		write_reg(jkaos_pkg::REG_KEY_LENGTH, {59'd0, len});
	endtask

	// result side: random stalls, plus one long hold on request
	initial begin
		int unsigned burst;
		burst        = 0;
		result.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req     = 1'b0;
				result.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (burst > 0) begin
				result.ready = 1'b0;
				burst--;
			end else if (idling_on && $urandom_range(0, 5) == 0) begin
				result.ready = 1'b0;
				burst        = $urandom_range(0, 7);
			end else begin
				result.ready = 1'b1;
			end
		end
	end

	initial begin
		jkaos_pkg::result_t got;
		forever begin
			@(posedge clk);
			if (arst_n && result.valid === 1'b1 && result.ready === 1'b1) begin
				got.byte_out        = result.byte_out;
				got.is_object_byte  = result.is_object_byte;
				got.object_last     = result.object_last;
				got.is_status       = result.is_status;
				got.status          = result.status;
				got.object_count    = result.object_count;
				got.partial_dropped = result.partial_dropped;
				if (expected_results.size() == 0)
					report_mismatch("result with none expected", {8'd0, got.byte_out}, '0);
				else
					check_result(got, expected_results.pop_front());
			end
		end
	end

	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		directed_row_t row;
		int unsigned   sent;
		text.valid        = 1'b0;
		text.data_byte    = '0;
		text.end_of_input = 1'b0;
		cfg.valid         = 1'b0;
		cfg.index         = '0;
		cfg.data          = '0;
		hold_req          = 1'b0;
		idling_on         = 1'b1;
		mismatches        = 0;
		key_chars         = '0;
		key_len           = 5'd1;
		restart_scan();
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (DIRECTED_ROWS[i]) begin
			row = DIRECTED_ROWS[i];
			send_item(jkaos_pkg::item_t'{row.data, row.eoi}, row.typed,
				mk_status(row.st, row.count, row.partial));
		end

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: configure(key_word(), key_word(), 5'd0);
				1: configure(key_word(), key_word(), 5'd1);
				2: configure('1, '1, 5'd16);
				3: configure(key_word(), key_word(), 5'd31);
				4: configure('0, '0, 5'd5);
				default: configure(key_word(), key_word(), 5'($urandom_range(2, 15)));
			endcase
			sent = 0;
			if (p == 1)
				hold_req = 1'b1;
			while (sent < PHASE_ITEMS) begin
				idling_on = ($urandom_range(0, 3) != 0);
				gen_doc(p == 1 && sent == 0);
				sent += doc_q.size();
				send_doc();
				if (p == 3 || $urandom_range(0, 5) == 0)
					wait_drained();
			end
		end

		// no idling from here on: depth limit
		idling_on = 1'b0;
		configure(key_word(), key_word(), 5'd3);
		add_key_string(1'b0);
		add_byte(jkaos_pkg::CH_LBRACKET);
		repeat (DEPTH_OPENS) add_byte(jkaos_pkg::CH_LBRACE);
		repeat (DEPTH_CLOSES) add_byte(jkaos_pkg::CH_RBRACE);
		add_byte(jkaos_pkg::CH_RBRACKET);
		add_end();
		send_doc();

		settle();
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- json_keyed_array_object_splitter_top.f -----
hdl/jkaos_pkg.sv
hdl/jkaos_if.sv
hdl/jkaos_scan_core.sv
hdl/jkaos_out_stage.sv
hdl/json_keyed_array_object_splitter_top.sv
sim/tb_json_keyed_array_object_splitter_top.sv
